FILE: sv/ifp_pkg.sv
`default_nettype none

package ifp_pkg;

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RawW    = 16;
  localparam int unsigned FsW     = 12;
  localparam int unsigned AxisW   = 27;
  localparam int unsigned KindW   = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned CfgIdxW = 2;

  // The product of a signed raw value and a zero-extended full scale.
  localparam int unsigned ProdW = RawW + FsW + 1;

  // Frame layout: header, type, three little-endian values, two spare bytes, checksum.
  localparam int unsigned FrameLen  = 11;
  localparam int unsigned StoreLen  = FrameLen - 1;
  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  localparam logic [ByteW-1:0] HeaderByte = 8'h55;
  localparam logic [ByteW-1:0] TypeAccel  = 8'h51;
  localparam logic [ByteW-1:0] TypeRate   = 8'h52;
  localparam logic [ByteW-1:0] TypeAngle  = 8'h53;

  // Full-scale reset values.
  localparam logic [FsW-1:0] AccelFsReset = 12'd16;
  localparam logic [FsW-1:0] RateFsReset  = 12'd2000;
  localparam logic [FsW-1:0] AngleFsReset = 12'd180;

  // Saturation limits of an axis result.
  localparam logic signed [AxisW-1:0] AxisMax = {1'b0, {(AxisW-1){1'b1}}};
  localparam logic signed [AxisW-1:0] AxisMin = {1'b1, {(AxisW-1){1'b0}}};

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_FS = 2'd0,
    CFG_RATE_FS  = 2'd1,
    CFG_ANGLE_FS = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

FILE: sv/ifp_axis_scale.sv
`default_nettype none

module ifp_axis_scale
  import ifp_pkg::*;
(
  input  wire logic signed [RawW-1:0]  raw_i,
  input  wire logic        [FsW-1:0]   fs_i,
  output logic signed      [AxisW-1:0] axis_o
);

  logic signed [ProdW-1:0] prod;
  logic [ProdW-AxisW:0]    top_bits;

  // Signed raw count times the unsigned full scale.
  assign prod     = ProdW'(raw_i) * ProdW'($signed({1'b0, fs_i}));
  assign top_bits = prod[ProdW-1:AxisW-1];

  // Clamp to the axis range when the upper bits are not a plain sign extension.
  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      axis_o = prod[AxisW-1:0];
    end else if (prod[ProdW-1]) begin
      axis_o = AxisMin;
    end else begin
      axis_o = AxisMax;
    end
  end

endmodule

`default_nettype wire

FILE: sv/imu_serial_frame_parser_top.sv
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  rx_byte_i
// out       output     out_valid_o / out_stall_i kind_o, axis_x_o, axis_y_o, axis_z_o
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One byte is accepted per cycle when the result path is not backed up.
// After its checksum byte is accepted, a result is captured first in the decoded-frame stage
// and then, after the multiply and clamp, in the output register.
// Reset clears the byte position, the pipeline valids and restores the full-scale registers.
// A stalled output holds its item; the input stalls only when both result stages are full.

module imu_serial_frame_parser_top
  import ifp_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [ByteW-1:0]          rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [KindW-1:0]               kind_o,
  output logic signed [AxisW-1:0]        axis_x_o,
  output logic signed [AxisW-1:0]        axis_y_o,
  output logic signed [AxisW-1:0]        axis_z_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [FsW-1:0]            cfg_wdata_i
);

  // Full-scale registers.
  logic [FsW-1:0] accel_fs_q, rate_fs_q, angle_fs_q;

  // Frame assembly state.
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] frame_q [StoreLen];

  // Decoded frame stage.
  logic                   s1_valid_q, s1_valid_d;
  kind_e                  s1_kind_q;
  logic [FsW-1:0]         s1_fs_q;
  logic signed [RawW-1:0] s1_raw_q [3];

  // Output register.
  logic                    out_valid_q;
  kind_e                   out_kind_q;
  logic signed [AxisW-1:0] out_axis_q [3];
  logic signed [AxisW-1:0] axis_scaled [3];

  logic  out_ready, s1_ready, in_acc;
  logic  frame_end, sum_ok, type_ok, frame_hit;
  kind_e frame_kind;
  logic [FsW-1:0] frame_fs;

  // Handshake: each stage loads when it is empty or its content moves on.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_fs_q <= AccelFsReset;
      rate_fs_q  <= RateFsReset;
      angle_fs_q <= AngleFsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACCEL_FS: accel_fs_q <= cfg_wdata_i;
        CFG_RATE_FS:  rate_fs_q  <= cfg_wdata_i;
        CFG_ANGLE_FS: angle_fs_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame type decode picks the kind and its full scale.
  always_comb begin
    type_ok    = 1'b1;
    frame_kind = KIND_ACCEL;
    frame_fs   = accel_fs_q;
    unique case (frame_q[1])
      TypeAccel: begin
        frame_kind = KIND_ACCEL;
        frame_fs   = accel_fs_q;
      end
      TypeRate: begin
        frame_kind = KIND_RATE;
        frame_fs   = rate_fs_q;
      end
      TypeAngle: begin
        frame_kind = KIND_ANGLE;
        frame_fs   = angle_fs_q;
      end
      default: type_ok = 1'b0;
    endcase
  end

  // The checksum byte closes a frame; a position past the last one also counts as an end.
  assign frame_end = (pos_q >= LastPos);
  assign sum_ok    = (sum_q == rx_byte_i);
  assign frame_hit = in_acc && frame_end && sum_ok && type_ok;

  // Byte position and running checksum.
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (in_acc) begin
      if (pos_q == '0) begin
        if (rx_byte_i == HeaderByte) begin
          pos_d = PosW'(1);
          sum_d = rx_byte_i;
        end
      end else if (!frame_end) begin
        pos_d = pos_q + PosW'(1);
        sum_d = sum_q + rx_byte_i;
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // Frame bytes are stored at the current position until the checksum arrives.
  always_ff @(posedge clk_i) begin
    if (in_acc && !frame_end && ((pos_q != '0) || (rx_byte_i == HeaderByte))) begin
      frame_q[pos_q] <= rx_byte_i;
    end
  end

  // Decoded frame stage.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (frame_hit) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_hit) begin
      s1_kind_q   <= frame_kind;
      s1_fs_q     <= frame_fs;
      s1_raw_q[0] <= {frame_q[3], frame_q[2]};
      s1_raw_q[1] <= {frame_q[5], frame_q[4]};
      s1_raw_q[2] <= {frame_q[7], frame_q[6]};
    end
  end

  // One multiply-and-clamp unit per axis.
  for (genvar g = 0; g < 3; g++) begin : g_axis
    ifp_axis_scale u_scale (
      .raw_i  (s1_raw_q[g]),
      .fs_i   (s1_fs_q),
      .axis_o (axis_scaled[g])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_kind_q    <= s1_kind_q;
      out_axis_q[0] <= axis_scaled[0];
      out_axis_q[1] <= axis_scaled[1];
      out_axis_q[2] <= axis_scaled[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign axis_x_o    = out_axis_q[0];
  assign axis_y_o    = out_axis_q[1];
  assign axis_z_o    = out_axis_q[2];

  // The position never runs past the checksum byte.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("byte position out of range");

  // A byte other than the header at the frame start leaves the position at zero.
  a_bad_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (pos_q == '0) && (rx_byte_i != HeaderByte)) |=> (pos_q == '0))
    else $error("bad header byte started a frame");

  // A decoded frame appears only after a checksum byte was taken.
  a_s1_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(in_acc && frame_end))
    else $error("decoded frame without checksum byte");

  // With both result stages full and the output stalled, no byte may be taken.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled with result path full");

endmodule

`default_nettype wire

FILE: verif/tb_imu_serial_frame_parser_top.sv
module tb_imu_serial_frame_parser_top;
  import ifp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted item before the run is declared hung.
  localparam int unsigned WatchdogLimit = 3000;
  // Cycles allowed for the result pipeline to empty before a register write.
  localparam int unsigned SettleCycles = 6;

  // Register index outside the defined set; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  // A frame type that decodes to no kind.
  localparam logic [ByteW-1:0] TypeUnknown = 8'h50;

  typedef struct packed {
    kind_e                    kind;
    logic signed [AxisW-1:0]  axis_x;
    logic signed [AxisW-1:0]  axis_y;
    logic signed [AxisW-1:0]  axis_z;
  } imu_sample_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic [ByteW-1:0]         rx_byte = '0;
  logic                     out_stall = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx = '0;
  logic [FsW-1:0]           cfg_wdata = '0;

  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [KindW-1:0]         kind_o;
  logic signed [AxisW-1:0]  axis_x_o;
  logic signed [AxisW-1:0]  axis_y_o;
  logic signed [AxisW-1:0]  axis_z_o;

  // Shadow copy of the parser state and of the full-scale registers.
  logic [FsW-1:0]           accel_fs = AccelFsReset;
  logic [FsW-1:0]           rate_fs = RateFsReset;
  logic [FsW-1:0]           angle_fs = AngleFsReset;
  logic [PosW-1:0]          frame_pos = '0;
  logic [ByteW-1:0]         frame_bytes [StoreLen];

  imu_sample_t              expected_samples [$];
  int unsigned              mismatch_count = 0;
  int unsigned              quiet_cycles = 0;
  bit                       gapless = 1'b0;

  imu_serial_frame_parser_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .kind_o      (kind_o),
    .axis_x_o    (axis_x_o),
    .axis_y_o    (axis_y_o),
    .axis_z_o    (axis_z_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Signed raw count times the full scale, clamped to the axis range.
  function automatic logic signed [AxisW-1:0] scaled_axis(logic [ByteW-1:0] lo,
                                                          logic [ByteW-1:0] hi,
                                                          logic [FsW-1:0] fs);
    logic signed [RawW-1:0] raw;
    longint                 prod;
    raw  = {hi, lo};
    prod = longint'(raw) * longint'(fs);
    if (prod > longint'(AxisMax)) prod = longint'(AxisMax);
    if (prod < longint'(AxisMin)) prod = longint'(AxisMin);
    return prod[AxisW-1:0];
  endfunction

  // Advance the shadow parser by one byte and queue a sample on a good frame.
  function automatic void absorb_rx_byte(logic [ByteW-1:0] b);
    logic [ByteW-1:0] sum;
    imu_sample_t      sample;
    logic [FsW-1:0]   fs;
    bit               known;
    sum   = '0;
    known = 1'b1;
    fs    = '0;
    if (frame_pos == '0) begin
      if (b == HeaderByte) begin
        frame_bytes[0] = b;
        frame_pos = PosW'(1);
      end
    end else if (frame_pos < LastPos) begin
      frame_bytes[frame_pos] = b;
      frame_pos = frame_pos + PosW'(1);
    end else begin
      frame_pos = '0;
      for (int i = 0; i < StoreLen; i++) sum = sum + frame_bytes[i];
      if (sum == b) begin
        case (frame_bytes[1])
          TypeAccel: begin
            sample.kind = KIND_ACCEL;
            fs = accel_fs;
          end
          TypeRate: begin
            sample.kind = KIND_RATE;
            fs = rate_fs;
          end
          TypeAngle: begin
            sample.kind = KIND_ANGLE;
            fs = angle_fs;
          end
          default: known = 1'b0;
        endcase
        if (known) begin
          sample.axis_x = scaled_axis(frame_bytes[2], frame_bytes[3], fs);
          sample.axis_y = scaled_axis(frame_bytes[4], frame_bytes[5], fs);
          sample.axis_z = scaled_axis(frame_bytes[6], frame_bytes[7], fs);
          expected_samples.push_back(sample);
        end
      end
    end
  endfunction

  function automatic void load_full_scale(logic [CfgIdxW-1:0] idx, logic [FsW-1:0] value);
    case (idx)
      CFG_ACCEL_FS: accel_fs = value;
      CFG_RATE_FS:  rate_fs = value;
      CFG_ANGLE_FS: angle_fs = value;
      default: ;
    endcase
  endfunction

  function automatic void report_field(string field, logic signed [AxisW-1:0] want,
                                       logic signed [AxisW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Sample every handshake at the clock edge: register writes and input items update
  // the shadow model, output items are compared with the oldest expected sample.
  always @(posedge clk_i) begin
    imu_sample_t want;
    bit          moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        moved = 1'b1;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d x %0d y %0d z %0d",
                   $realtime, kind_o, axis_x_o, axis_y_o, axis_z_o);
          mismatch_count++;
        end else begin
          want = expected_samples.pop_front();
          report_field("kind", AxisW'(want.kind), AxisW'(kind_o));
          report_field("axis_x", want.axis_x, axis_x_o);
          report_field("axis_y", want.axis_y, axis_y_o);
          report_field("axis_z", want.axis_z, axis_z_o);
        end
      end
      if (cfg_we) begin
        moved = 1'b1;
        load_full_scale(cfg_idx, cfg_wdata);
      end
      if (in_valid && !in_stall_o) begin
        moved = 1'b1;
        absorb_rx_byte(rx_byte);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: watchdog expired with %0d results outstanding",
             $realtime, expected_samples.size());
    $display("tb_imu_serial_frame_parser_top: FAIL");
    $finish;
  end

  // Receiver back-pressure: long clear stretches now and then, mostly short stalls.
  initial begin
    int run;
    int pick;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk_i);
      pick = $urandom_range(0, 99);
      if (pick < 80) run = $urandom_range(1, 3);
      else if (pick < 97) run = $urandom_range(4, 10);
      else run = $urandom_range(20, 40);
      out_stall <= 1'b1;
      repeat (run) @(posedge clk_i);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (gapless || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one byte and hold it until the block takes it.
  task automatic push_rx_byte(logic [ByteW-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending until every expected result has left the block.
  task automatic drain_results(int extra);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_full_scale(logic [CfgIdxW-1:0] idx, logic [FsW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all_full_scales(logic [FsW-1:0] accel, logic [FsW-1:0] rate,
                                     logic [FsW-1:0] angle);
    drain_results(SettleCycles);
    write_full_scale(CFG_ACCEL_FS, accel);
    write_full_scale(CFG_RATE_FS, rate);
    write_full_scale(CFG_ANGLE_FS, angle);
  endtask

  // Build one 11-byte frame; a bad checksum flips at least one bit of the sum.
  task automatic send_frame(logic [ByteW-1:0] frame_type, logic [RawW-1:0] x,
                            logic [RawW-1:0] y, logic [RawW-1:0] z, bit bad_sum);
    logic [ByteW-1:0] body [StoreLen];
    logic [ByteW-1:0] sum;
    body[0] = HeaderByte;
    body[1] = frame_type;
    body[2] = x[7:0];
    body[3] = x[15:8];
    body[4] = y[7:0];
    body[5] = y[15:8];
    body[6] = z[7:0];
    body[7] = z[15:8];
    body[8] = 8'($urandom);
    body[9] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < StoreLen; i++) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < StoreLen; i++) push_rx_byte(body[i]);
    push_rx_byte(sum);
  endtask

  // Raw counts lean toward the extremes so that saturation is reached often.
  function automatic logic [RawW-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly good frames of the three kinds, with some unknown types, bad sums,
  // stray bytes that break the framing, and an occasional full drain.
  task automatic send_random_frames(int count);
    int               pick;
    logic [ByteW-1:0] frame_type;
    bit               bad_sum;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) frame_type = TypeAccel;
      else if (pick < 60) frame_type = TypeRate;
      else if (pick < 88) frame_type = TypeAngle;
      else frame_type = 8'($urandom);
      bad_sum = ($urandom_range(0, 9) == 0);
      gapless = ($urandom_range(0, 4) == 0);
      send_frame(frame_type, pick_raw(), pick_raw(), pick_raw(), bad_sum);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) push_rx_byte(8'($urandom));
      end
      if ($urandom_range(0, 11) == 0) drain_results(0);
    end
    gapless = 1'b0;
  endtask

  // Bad headers, each kind with extreme counts, an unknown type and a bad checksum.
  task automatic test_directed_frames();
    push_rx_byte(8'h00);
    push_rx_byte(8'hFF);
    send_frame(TypeAccel, 16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
    send_frame(TypeAngle, 16'h0000, 16'h0001, 16'h8001, 1'b0);
    send_frame(TypeUnknown, 16'h1234, 16'h8000, 16'h7FFF, 1'b0);
    send_frame(TypeRate, 16'h7FFF, 16'h8000, 16'h0100, 1'b1);
    send_frame(TypeRate, 16'h7FFF, 16'h8000, 16'h0100, 1'b0);
  endtask

  task automatic test_reset_scales();
    send_random_frames(8);
  endtask

  task automatic test_scale_limits();
    set_all_full_scales(12'd2048, 12'd2048, 12'd2048);
    send_random_frames(6);
    set_all_full_scales(12'd1, 12'd1, 12'd1);
    send_random_frames(6);
  endtask

  // Zero, values past the nominal range and a write to the unused index.
  task automatic test_scale_out_of_range();
    set_all_full_scales(12'd0, 12'd4095, 12'd2049);
    write_full_scale(CfgIdxSpare, 12'hFFF);
    send_frame(TypeAccel, 16'h7FFF, 16'h8000, 16'h0001, 1'b0);
    send_frame(TypeRate, 16'h7FFF, 16'h8000, 16'h0001, 1'b0);
    send_frame(TypeAngle, 16'h7FFF, 16'h8000, 16'h0001, 1'b0);
    send_random_frames(6);
  endtask

  task automatic test_random_scales();
    repeat (3) begin
      set_all_full_scales(12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)),
                          12'($urandom_range(1, 2048)));
      send_random_frames(3);
      drain_results(0);
      send_random_frames(2);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_reset_scales();
    test_scale_limits();
    test_scale_out_of_range();
    test_random_scales();

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_imu_serial_frame_parser_top: PASS");
    end else begin
      $display("tb_imu_serial_frame_parser_top: FAIL");
    end
    $finish;
  end

endmodule
